>>> rtl/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types and constants for the insertion sorter: payload structs and
// the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int KEY_W        = 32;
    localparam int MAX_KEYS_DEF = 32;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_value;
        logic                    final_key;
    } in_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_value;
        logic                    last_out;
        logic                    overflowed;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic accept;     // capture key, pos <= fill, idx <= 0
        logic set_drop;   // key dropped, store full
        logic probe_rd;   // read entry pos-1
        logic shift;      // move read entry up to pos, pos--, read pos-2
        logic place;      // write key at pos, fill++
        logic emit_rd;    // read entry idx, idx++
        logic clear;      // empty the store, clear drop flag
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_final;   // final mark of the item on the input port
        logic full;
        logic empty;
        logic fin;        // captured final mark
        logic pos_zero;
        logic pos_one;
        logic greater;    // read entry strictly above key
        logic idx_end;    // every stored entry has been read
    } stat_t;

endpackage

>>> rtl/insertion_sorter_core.sv
// ----------------------------------------------------------------------------
// insertion_sorter_core
// Inserts signed keys into a sorted store; on the key marked final, emits the
// stored keys in ascending order and empties the store.
//
//   channel   handshake           payload
//   input     start & !busy       item   (key_value, final_key)
//   output    strobe, one cycle   result (sorted_value, last_out, overflowed)
//
// A key on an empty store is placed without a compare; otherwise the store is
// walked downward, one entry a cycle, shifting each entry greater than the key
// up, and the key is written into the gap. A key arriving on a full store is
// dropped. On the final key the sweep gives one transfer a cycle.
// Reset empties the store at once; no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module insertion_sorter_core #(
    parameter int MAX_KEYS = isort_pkg::MAX_KEYS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  isort_pkg::in_t    item,
    output logic              strobe,
    output isort_pkg::out_t   result
);

    isort_pkg::cmd_t  cmd;
    isort_pkg::stat_t stat;

    isort_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe)
    );

    isort_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

>>> rtl/isort_datapath.sv
// ----------------------------------------------------------------------------
// isort_datapath
// Sorted key store with one write and one registered read port, insertion
// pointer, emit index, fill count and sticky drop flag.
// ----------------------------------------------------------------------------
module isort_datapath #(
    parameter int MAX_KEYS = isort_pkg::MAX_KEYS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  isort_pkg::in_t      item,
    input  isort_pkg::cmd_t     cmd,
    output isort_pkg::stat_t    stat,
    output isort_pkg::out_t     result
);

    localparam int ADDR_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W  = $clog2(MAX_KEYS + 1);

    logic [isort_pkg::KEY_W-1:0] mem [MAX_KEYS];

    logic signed [isort_pkg::KEY_W-1:0] key_reg;
    logic signed [isort_pkg::KEY_W-1:0] rd_data_reg;
    logic                               fin_reg;
    logic [CNT_W-1:0]                   pos_reg;
    logic [CNT_W-1:0]                   idx_reg;
    logic [CNT_W-1:0]                   fill_reg;
    logic [CNT_W-1:0]                   fill_next;
    logic                               drop_reg;
    logic                               drop_next;

    logic [CNT_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  pos_m2;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [isort_pkg::KEY_W-1:0] wr_data;

    assign pos_m1 = pos_reg - CNT_W'(1);
    assign pos_m2 = pos_reg - CNT_W'(2);

    // read port: probe, shift walk or emit sweep
    always_comb
    begin
        rd_en   = cmd.probe_rd | cmd.shift | cmd.emit_rd;
        rd_addr = idx_reg[ADDR_W-1:0];
        if (cmd.probe_rd)
        begin
            rd_addr = pos_m1[ADDR_W-1:0];
        end
        else if (cmd.shift)
        begin
            rd_addr = pos_m2[ADDR_W-1:0];
        end
    end

    // write port: shifted entry or the new key
    always_comb
    begin
        wr_en   = cmd.shift | cmd.place;
        wr_addr = pos_reg[ADDR_W-1:0];
        wr_data = cmd.shift ? rd_data_reg : key_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg <= item.key_value;
            fin_reg <= item.final_key;
            pos_reg <= fill_reg;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.shift)
            begin
                pos_reg <= pos_m1;
            end
            if (cmd.emit_rd)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        drop_next = drop_reg;
        if (cmd.place)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        if (cmd.set_drop)
        begin
            drop_next = 1'b1;
        end
        if (cmd.clear)
        begin
            fill_next = '0;
            drop_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            drop_reg <= drop_next;
        end
    end

    assign stat.in_final = item.final_key;
    assign stat.full     = (fill_reg == CNT_W'(MAX_KEYS));
    assign stat.empty    = (fill_reg == '0);
    assign stat.fin      = fin_reg;
    assign stat.pos_zero = (pos_reg == '0);
    assign stat.pos_one  = (pos_reg == CNT_W'(1));
    assign stat.greater  = (rd_data_reg > key_reg);
    assign stat.idx_end  = (idx_reg == fill_reg);

    assign result.sorted_value = rd_data_reg;
    assign result.last_out     = (idx_reg == fill_reg);
    assign result.overflowed   = drop_reg;

endmodule

>>> rtl/isort_ctrl.sv
// ----------------------------------------------------------------------------
// isort_ctrl
// Sequencer for the insertion sorter: takes a key, or drops it on a full store,
// walks the store downward shifting larger entries, places the key, and on the
// final key sweeps the store out in ascending order.
// ----------------------------------------------------------------------------
module isort_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  isort_pkg::stat_t  stat,
    output isort_pkg::cmd_t   cmd,
    output logic              busy,
    output logic              strobe
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_PLACE,
        S_EMIT_START,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (stat.full)
                    begin
                        cmd.set_drop = 1'b1;
                        state_next   = stat.in_final ? S_EMIT_START : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (stat.pos_zero)
                begin
                    cmd.place  = 1'b1;
                    state_next = stat.fin ? S_EMIT_START : S_IDLE;
                end
                else
                begin
                    cmd.probe_rd = 1'b1;
                    state_next   = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.greater)
                begin
                    // shift up; the next lower entry is read in the same cycle
                    cmd.shift  = 1'b1;
                    state_next = stat.pos_one ? S_PLACE : S_CMP;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = stat.fin ? S_EMIT_START : S_IDLE;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = stat.fin ? S_EMIT_START : S_IDLE;
            end
            S_EMIT_START:
            begin
                if (stat.empty)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.emit_rd = 1'b1;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // one transfer per cycle, next entry read alongside
                if (stat.idx_end)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.emit_rd = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = (state_reg == S_EMIT);

endmodule
